// ===== rtl/wfpd_pkg.sv =====
`timescale 1ns / 1ps
// wfpd_pkg: field widths, register codes and register reset values of the wall-follow pid drive
// no dependencies; imported by every module of the block

package wfpd_pkg;

  // sample width default, overridable at the top level
  localparam int SAMPLE_BITS_DEF = 12;

  // configuration register widths
  localparam int SETPOINT_W = 16;
  localparam int GAIN_W     = 24;
  localparam int ILIM_W     = 15;
  localparam int CLIM_W     = 16;
  localparam int SPAN_W     = 14;
  localparam int BASE_W     = 14;
  localparam int CFG_DATA_W = 24;

  // result widths
  localparam int SPEED_W = 16;
  localparam int CTRL_W  = 15;

  // internal datapath widths
  localparam int ERR_W     = 18;
  localparam int ESUM_W    = 16;
  localparam int DELTA_W   = ERR_W + 1;
  localparam int PID_W     = 46;
  localparam int CLIM_FRAC = 20;
  localparam int LIM_W     = CLIM_W + CLIM_FRAC;
  localparam int QUO_W     = SPAN_W + 1;

  typedef enum logic [2:0] {
    REG_SETPOINT  = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_ILIM      = 3'd4,
    REG_CLIM      = 3'd5,
    REG_SPAN      = 3'd6,
    REG_BASE      = 3'd7
  } cfg_idx_t;

  localparam logic [SETPOINT_W-1:0] SETPOINT_RST = 16'd1592;
  localparam logic [GAIN_W-1:0]     GAIN_P_RST   = 24'd6225920;
  localparam logic [GAIN_W-1:0]     GAIN_I_RST   = 24'd1;
  localparam logic [GAIN_W-1:0]     GAIN_D_RST   = 24'd65536;
  localparam logic [ILIM_W-1:0]     ILIM_RST     = 15'd800;
  localparam logic [CLIM_W-1:0]     CLIM_RST     = 16'd10000;
  localparam logic [SPAN_W-1:0]     SPAN_RST     = 14'd10813;
  localparam logic [BASE_W-1:0]     BASE_RST     = 14'd10813;

endpackage

// ===== rtl/wfpd_mean.sv =====
`timescale 1ns / 1ps
// wfpd_mean: bit-serial weighted mean (32a + 32b + 16c + 2) / 5 of the three samples
// depends on wfpd_pkg

module wfpd_mean #(
  parameter int SAMPLE_BITS = wfpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] smp_a,
  input  logic [SAMPLE_BITS-1:0] smp_b,
  input  logic [SAMPLE_BITS-1:0] smp_c,
  output logic [SAMPLE_BITS+3:0] mean,
  output logic                   done
);
  import wfpd_pkg::*;

  localparam int NUM_W  = SAMPLE_BITS + 7;
  localparam int MEAN_W = SAMPLE_BITS + 4;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam logic [3:0] DIVISOR = 4'd5;

  logic [NUM_W-1:0]  num_r, num_nxt, num_init;
  logic [2:0]        rem_r, rem_nxt;
  logic [MEAN_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [3:0]        trial;
  logic              fits;

  assign num_init = (NUM_W'(smp_a) << 5) + (NUM_W'(smp_b) << 5) + (NUM_W'(smp_c) << 4)
                  + NUM_W'(2);
  assign trial    = {rem_r, num_r[NUM_W-1]};
  assign fits     = (trial >= DIVISOR);

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num_init;
      rem_nxt  = 3'd0;
      quo_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one quotient bit per cycle, remainder stays below five
      num_nxt = num_r << 1;
      rem_nxt = fits ? 3'(trial - DIVISOR) : trial[2:0];
      quo_nxt = {quo_r[MEAN_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign mean = quo_r;
  assign done = done_r;

endmodule

// ===== rtl/wfpd_pid_mac.sv =====
`timescale 1ns / 1ps
// wfpd_pid_mac: shift-and-add evaluation of gain_p*err + gain_i*esum + gain_d*delta
// depends on wfpd_pkg; one bit of each gain per cycle, msb first

module wfpd_pid_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [wfpd_pkg::GAIN_W-1:0]          gain_p,
  input  logic [wfpd_pkg::GAIN_W-1:0]          gain_i,
  input  logic [wfpd_pkg::GAIN_W-1:0]          gain_d,
  input  logic signed [wfpd_pkg::ERR_W-1:0]    err,
  input  logic signed [wfpd_pkg::ESUM_W-1:0]   esum,
  input  logic signed [wfpd_pkg::DELTA_W-1:0]  delta,
  output logic signed [wfpd_pkg::PID_W-1:0]    pid_sum,
  output logic                                 done
);
  import wfpd_pkg::*;

  localparam int TERM_W = DELTA_W + 2;
  localparam int CNT_W  = $clog2(GAIN_W + 1);

  logic [GAIN_W-1:0]         gp_r, gp_nxt, gi_r, gi_nxt, gd_r, gd_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [ESUM_W-1:0]  esum_r, esum_nxt;
  logic signed [DELTA_W-1:0] delta_r, delta_nxt;
  logic signed [PID_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic signed [TERM_W-1:0]  err_x, esum_x, delta_x, term;

  assign err_x   = {{(TERM_W-ERR_W){err_r[ERR_W-1]}}, err_r};
  assign esum_x  = {{(TERM_W-ESUM_W){esum_r[ESUM_W-1]}}, esum_r};
  assign delta_x = {{(TERM_W-DELTA_W){delta_r[DELTA_W-1]}}, delta_r};

  // partial sum for the current gain bit position
  assign term = (gp_r[GAIN_W-1] ? err_x : '0)
              + (gi_r[GAIN_W-1] ? esum_x : '0)
              + (gd_r[GAIN_W-1] ? delta_x : '0);

  always_comb begin
    gp_nxt    = gp_r;
    gi_nxt    = gi_r;
    gd_nxt    = gd_r;
    err_nxt   = err_r;
    esum_nxt  = esum_r;
    delta_nxt = delta_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      gp_nxt    = gain_p;
      gi_nxt    = gain_i;
      gd_nxt    = gain_d;
      err_nxt   = err;
      esum_nxt  = esum;
      delta_nxt = delta;
      acc_nxt   = '0;
      cnt_nxt   = CNT_W'(GAIN_W);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      acc_nxt = (acc_r <<< 1) + {{(PID_W-TERM_W){term[TERM_W-1]}}, term};
      gp_nxt  = gp_r << 1;
      gi_nxt  = gi_r << 1;
      gd_nxt  = gd_r << 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    gp_r    <= gp_nxt;
    gi_r    <= gi_nxt;
    gd_r    <= gd_nxt;
    err_r   <= err_nxt;
    esum_r  <= esum_nxt;
    delta_r <= delta_nxt;
    acc_r   <= acc_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign pid_sum = acc_r;
  assign done    = done_r;

endmodule

// ===== rtl/wfpd_scale.sv =====
`timescale 1ns / 1ps
// wfpd_scale: clamps the pid sum to the control limit and rescales it to the output span
// depends on wfpd_pkg; bit-serial multiply by span, then restoring divide with rounding

module wfpd_scale (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [wfpd_pkg::PID_W-1:0]  pid_sum,
  input  logic [wfpd_pkg::CLIM_W-1:0]        ctrl_limit,
  input  logic [wfpd_pkg::SPAN_W-1:0]        span,
  output logic signed [wfpd_pkg::CTRL_W-1:0] ctrl,
  output logic                               done
);
  import wfpd_pkg::*;

  localparam int PROD_W = LIM_W + SPAN_W;
  localparam int REM_W  = LIM_W + 1;
  localparam int CNT_W  = $clog2(QUO_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_MUL,
    S_DLOAD,
    S_DIV,
    S_ROUND
  } scale_state_t;

  scale_state_t             state_r, state_nxt;
  logic                     done_r, done_nxt;
  logic                     neg_r, neg_nxt;
  logic [PID_W-1:0]         mag_r, mag_nxt;
  logic [LIM_W-1:0]         mcl_r, mcl_nxt;
  logic [SPAN_W-1:0]        spn_r, spn_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [LIM_W-1:0]         rem_r, rem_nxt;
  logic [QUO_W-1:0]         low_r, low_nxt;
  logic [QUO_W-1:0]         quo_r, quo_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [CTRL_W-1:0] ctrl_r, ctrl_nxt;

  logic [LIM_W-1:0]         den;
  logic [REM_W-1:0]         trial;
  logic                     fits;
  logic [QUO_W:0]           quo_inc;
  logic [CTRL_W-1:0]        qmag;

  assign den     = {ctrl_limit, {CLIM_FRAC{1'b0}}};
  assign trial   = {rem_r, low_r[QUO_W-1]};
  assign fits    = (trial >= {1'b0, den});
  // quotient carries one extra fraction bit; add half and drop it
  assign quo_inc = {1'b0, quo_r} + (QUO_W+1)'(1);
  assign qmag    = quo_inc[QUO_W:1];

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    mcl_nxt   = mcl_r;
    spn_nxt   = spn_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    low_nxt   = low_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    ctrl_nxt  = ctrl_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          neg_nxt   = pid_sum[PID_W-1];
          mag_nxt   = pid_sum[PID_W-1] ? PID_W'(-pid_sum) : PID_W'(pid_sum);
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        mcl_nxt   = (mag_r > {{(PID_W-LIM_W){1'b0}}, den}) ? den : mag_r[LIM_W-1:0];
        spn_nxt   = span;
        prod_nxt  = '0;
        cnt_nxt   = CNT_W'(SPAN_W);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt = (prod_r << 1) + (spn_r[SPAN_W-1] ? PROD_W'(mcl_r) : '0);
        spn_nxt  = spn_r << 1;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_DLOAD;
        end
      end
      S_DLOAD: begin
        // high part of the doubled product is already below the divisor
        rem_nxt   = prod_r[PROD_W-1:SPAN_W];
        low_nxt   = {prod_r[SPAN_W-1:0], 1'b0};
        quo_nxt   = '0;
        cnt_nxt   = CNT_W'(QUO_W);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = fits ? LIM_W'(trial - {1'b0, den}) : trial[LIM_W-1:0];
        low_nxt = low_r << 1;
        quo_nxt = {quo_r[QUO_W-2:0], fits};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        if (ctrl_limit == '0) begin
          ctrl_nxt = '0;
        end else begin
          ctrl_nxt = neg_r ? -$signed(qmag) : $signed(qmag);
        end
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    mcl_r  <= mcl_nxt;
    spn_r  <= spn_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    low_r  <= low_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    ctrl_r <= ctrl_nxt;
  end

  assign ctrl = ctrl_r;
  assign done = done_r;

endmodule

// ===== rtl/wall_follow_pid_drive.sv =====
`timescale 1ns / 1ps
// wall_follow_pid_drive: top level of the wall-following steering controller
// depends on wfpd_pkg, wfpd_mean, wfpd_pid_mac and wfpd_scale
//
// channel   direction  handshake              payload
// in_       in         in_valid / in_ready    three distance samples, SAMPLE_BITS each
// out_      out        out_valid / out_ready  left speed, right speed, control value
// cfg_      in         cfg_wr_en              cfg_index selects register, cfg_wdata
//
// one transaction at a time: the next input can be taken as soon as the result is valid;
// the work is mostly bit-serial, one bit a cycle: mean divider, gain multiply, span multiply
// and divider, with handoff states between them
// a finished result waits in the output register while the next transaction runs; if it
// is still there when the next result is ready, the datapath holds until it drains
// synchronous active-low reset restores register defaults, clears pid history, drops ready

module wall_follow_pid_drive #(
  parameter int SAMPLE_BITS = wfpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // sample channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [SAMPLE_BITS-1:0]                in_sensor_right_front,
  input  logic [SAMPLE_BITS-1:0]                in_sensor_left_side,
  input  logic [SAMPLE_BITS-1:0]                in_sensor_left_front,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [wfpd_pkg::SPEED_W-1:0]   out_left_speed,
  output logic signed [wfpd_pkg::SPEED_W-1:0]   out_right_speed,
  output logic signed [wfpd_pkg::CTRL_W-1:0]    out_control_value,
  // register writes
  input  logic                                  cfg_wr_en,
  input  wfpd_pkg::cfg_idx_t                    cfg_index,
  input  logic [wfpd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import wfpd_pkg::*;

  localparam int MEAN_W = SAMPLE_BITS + 4;
  localparam int DIFF_W = ((MEAN_W > SETPOINT_W) ? MEAN_W : SETPOINT_W) + 2;
  localparam int ACC_W  = ERR_W + 1;
  localparam logic signed [DIFF_W-1:0] ERR_HI = DIFF_W'(2**(ERR_W-1) - 1);
  localparam logic signed [DIFF_W-1:0] ERR_LO = DIFF_W'(-(2**(ERR_W-1)));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_ERR,
    ST_PID,
    ST_SCALE,
    ST_DRAIN
  } drive_state_t;

  // configuration registers
  logic [SETPOINT_W-1:0] setpoint_r;
  logic [GAIN_W-1:0]     gain_p_r, gain_i_r, gain_d_r;
  logic [ILIM_W-1:0]     ilim_r;
  logic [CLIM_W-1:0]     clim_r;
  logic [SPAN_W-1:0]     span_r;
  logic [BASE_W-1:0]     base_r;

  // control and pid history
  drive_state_t              state_r, state_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [ESUM_W-1:0]  esum_r, esum_nxt;
  logic signed [ERR_W-1:0]   prev_r, prev_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SPEED_W-1:0] out_left_speed_r, left_nxt;
  logic signed [SPEED_W-1:0] out_right_speed_r, right_nxt;
  logic signed [CTRL_W-1:0]  out_control_value_r, ctrl_out_nxt;

  // unit connections
  logic                      mean_start, mean_done;
  logic [MEAN_W-1:0]         mean_val;
  logic                      mac_start, mac_done;
  logic signed [PID_W-1:0]   pid_sum;
  logic                      scale_done;
  logic signed [CTRL_W-1:0]  ctrl_val;

  // error path
  logic signed [DIFF_W-1:0]  sp_x, mean_x, diff;
  logic signed [ERR_W-1:0]   err_sat;
  logic signed [ACC_W-1:0]   esum_acc, ilim_pos, ilim_neg;
  logic signed [ESUM_W-1:0]  esum_new;
  logic signed [DELTA_W-1:0] delta;

  // wheel speeds
  logic signed [SPEED_W-1:0] base_x, ctrl_x;
  logic                      out_free;

  assign in_ready   = rst_n && (state_r == ST_IDLE);
  assign mean_start = in_valid && in_ready;
  assign mac_start  = (state_r == ST_ERR);
  assign out_free   = !out_valid_r || out_ready;

  // error = setpoint - mean, held to the 18-bit signed range
  assign sp_x    = {{(DIFF_W-SETPOINT_W){1'b0}}, setpoint_r};
  assign mean_x  = {{(DIFF_W-MEAN_W){1'b0}}, mean_val};
  assign diff    = sp_x - mean_x;
  assign err_sat = (diff > ERR_HI) ? ERR_HI[ERR_W-1:0] :
                   (diff < ERR_LO) ? ERR_LO[ERR_W-1:0] : diff[ERR_W-1:0];

  // integral with symmetric clamp, and derivative against the last error
  assign esum_acc = {{(ACC_W-ESUM_W){esum_r[ESUM_W-1]}}, esum_r} + {err_r[ERR_W-1], err_r};
  assign ilim_pos = {{(ACC_W-ILIM_W){1'b0}}, ilim_r};
  assign ilim_neg = -ilim_pos;
  assign esum_new = (esum_acc > ilim_pos) ? ilim_pos[ESUM_W-1:0] :
                    (esum_acc < ilim_neg) ? ilim_neg[ESUM_W-1:0] : esum_acc[ESUM_W-1:0];
  assign delta    = {err_r[ERR_W-1], err_r} - {prev_r[ERR_W-1], prev_r};

  // base is at most 16383 and |control| at most 16383, so 16 bits never overflow
  assign base_x = {{(SPEED_W-BASE_W){1'b0}}, base_r};
  assign ctrl_x = {{(SPEED_W-CTRL_W){ctrl_val[CTRL_W-1]}}, ctrl_val};

  wfpd_mean #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mean (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mean_start),
    .smp_a (in_sensor_right_front),
    .smp_b (in_sensor_left_side),
    .smp_c (in_sensor_left_front),
    .mean  (mean_val),
    .done  (mean_done)
  );

  wfpd_pid_mac u_pid_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mac_start),
    .gain_p  (gain_p_r),
    .gain_i  (gain_i_r),
    .gain_d  (gain_d_r),
    .err     (err_r),
    .esum    (esum_new),
    .delta   (delta),
    .pid_sum (pid_sum),
    .done    (mac_done)
  );

  wfpd_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (mac_done),
    .pid_sum    (pid_sum),
    .ctrl_limit (clim_r),
    .span       (span_r),
    .ctrl       (ctrl_val),
    .done       (scale_done)
  );

  // sequencer: one transaction walks mean, error update, pid, rescale, drain
  always_comb begin
    state_nxt     = state_r;
    err_nxt       = err_r;
    esum_nxt      = esum_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r;
    left_nxt      = out_left_speed_r;
    right_nxt     = out_right_speed_r;
    ctrl_out_nxt  = out_control_value_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (mean_done) begin
          err_nxt   = err_sat;
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        // history advances once per transaction, alongside the mac launch
        esum_nxt  = esum_new;
        prev_nxt  = err_r;
        state_nxt = ST_PID;
      end
      ST_PID: begin
        if (mac_done) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (scale_done) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          left_nxt      = base_x - ctrl_x;
          right_nxt     = base_x + ctrl_x;
          ctrl_out_nxt  = ctrl_val;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      esum_r      <= '0;
      prev_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      esum_r      <= esum_nxt;
      prev_r      <= prev_nxt;
    end
    err_r               <= err_nxt;
    out_left_speed_r    <= left_nxt;
    out_right_speed_r   <= right_nxt;
    out_control_value_r <= ctrl_out_nxt;
  end

  // register file; the user must write it only between transactions, the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= SETPOINT_RST;
      gain_p_r   <= GAIN_P_RST;
      gain_i_r   <= GAIN_I_RST;
      gain_d_r   <= GAIN_D_RST;
      ilim_r     <= ILIM_RST;
      clim_r     <= CLIM_RST;
      span_r     <= SPAN_RST;
      base_r     <= BASE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SETPOINT: setpoint_r <= cfg_wdata[SETPOINT_W-1:0];
        REG_GAIN_P:   gain_p_r   <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:   gain_i_r   <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:   gain_d_r   <= cfg_wdata[GAIN_W-1:0];
        REG_ILIM:     ilim_r     <= cfg_wdata[ILIM_W-1:0];
        REG_CLIM:     clim_r     <= cfg_wdata[CLIM_W-1:0];
        REG_SPAN:     span_r     <= cfg_wdata[SPAN_W-1:0];
        REG_BASE:     base_r     <= cfg_wdata[BASE_W-1:0];
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_speed    = out_left_speed_r;
  assign out_right_speed   = out_right_speed_r;
  assign out_control_value = out_control_value_r;

`ifndef SYNTH
  // integral is inside its clamp right after each update
  a_esum_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ERR) |=>
      (($signed(esum_r) <= $signed({1'b0, ilim_r})) &&
       ($signed(esum_r) >= -$signed({1'b0, ilim_r}))))
    else $error("error_sum outside integral limit");

  // the mean and rescale units report completion only in their own phase
  a_mean_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mean_done |-> (state_r == ST_MEAN))
    else $error("mean completion outside mean phase");

  a_scale_phase: assert property (@(posedge clk) disable iff (!rst_n)
    scale_done |-> (state_r == ST_SCALE))
    else $error("rescale completion outside rescale phase");

  // a loaded control value never exceeds the output span
  a_ctrl_span: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DRAIN) && out_free) |=>
      (($signed(out_control_value_r) <= $signed({1'b0, span_r})) &&
       ($signed(out_control_value_r) >= -$signed({1'b0, span_r}))))
    else $error("control value exceeds output span");

  // the two wheel speeds are symmetric about the base speed
  a_wheel_symmetry: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DRAIN) && out_free) |=>
      (({out_left_speed_r[SPEED_W-1], out_left_speed_r} +
        {out_right_speed_r[SPEED_W-1], out_right_speed_r}) ==
       {{(SPEED_W-BASE_W){1'b0}}, base_r, 1'b0}))
    else $error("wheel speeds not symmetric about base speed");
`endif

endmodule
